[hw/rtl/sqv_pkg.sv]
// sqv_pkg: shared types, constants and helpers of the sprite quad vertex generator
// no dependencies; used by every module under hw/rtl
`default_nettype none
package sqv_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [32:0] ONE_Q30  = 33'sd1073741824;

  localparam logic [31:0] ATAN_TBL [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [31:0] dest_x;
    logic signed [31:0] dest_y;
    logic signed [31:0] dest_w;
    logic signed [31:0] dest_h;
    logic signed [31:0] tex_x;
    logic signed [31:0] tex_y;
    logic signed [31:0] tex_w;
    logic signed [31:0] tex_h;
    logic [31:0]        colour_rgba;
    logic [31:0]        texture_id;
    logic signed [31:0] depth_value;
    logic [15:0]        turn_angle;
  } sprite_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic [31:0]        out_colour;
    logic [31:0]        out_texture;
    logic signed [31:0] out_depth;
    logic [1:0]         corner;
    logic               last_corner;
  } vertex_t;

  // sprite plus its cosine and sine in q1.30
  typedef struct packed {
    sprite_t            spr;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } job_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_BL = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_TR = 2'd3
  } corner_t;

  function automatic logic [31:0] sat36(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh07FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -36'sh080000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/sprite_quad_vertex_gen_core.sv]
// sprite_quad_vertex_gen_core: one sprite in, four vertices out (tl, bl, br, tr)
// path to the ports: input register, cordic stages, queue, products, output register
// vertices leave one per cycle unless held; the next sprite is taken with the last
// the cordic pipe takes a sprite each cycle unless full; credits cap sprites in flight
// reset (rst, synchronous) empties pipe, queue and output; no data is cleared
`default_nettype none
module sprite_quad_vertex_gen_core #(
  parameter int CORDIC_STEPS = sqv_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire sqv_pkg::sprite_t sprite,
  output logic                  empty,
  input  wire logic             pop,
  output sqv_pkg::vertex_t      vertex
);

  localparam int QDEPTH = CORDIC_STEPS / 4 + 3;

  logic          f_valid, q_valid, q_take;
  sqv_pkg::job_t f_job, q_job;

  sqv_front #(.CORDIC_STEPS(CORDIC_STEPS), .QDEPTH(QDEPTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .sprite(sprite),
    .release_credit(q_take), .job_valid(f_valid), .job(f_job)
  );

  sqv_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst), .wr_en(f_valid), .wr_job(f_job),
    .rd_valid(q_valid), .rd_job(q_job), .rd_en(q_take)
  );

  sqv_back u_back (
    .clk(clk), .rst(rst), .job_valid(q_valid), .job(q_job), .job_take(q_take),
    .empty(empty), .pop(pop), .vertex(vertex)
  );

endmodule
`default_nettype wire

[hw/rtl/sqv_front.sv]
// sqv_front: input acceptance and pipelined cordic sine/cosine, one stage per step
// depends on sqv_pkg; credit count keeps the pipe plus queue from overflowing
`default_nettype none
module sqv_front #(
  parameter int CORDIC_STEPS = sqv_pkg::CORDIC_STEPS_DEF,
  parameter int QDEPTH       = 7
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire sqv_pkg::sprite_t sprite,
  input  wire logic           release_credit,
  output logic                job_valid,
  output sqv_pkg::job_t       job
);

  localparam int CW = $clog2(QDEPTH + 1);

  logic [CW-1:0] credits;
  logic acc;

  logic                 vld  [CORDIC_STEPS+1];
  logic signed [32:0]   xr   [CORDIC_STEPS+1];
  logic signed [32:0]   yr   [CORDIC_STEPS+1];
  logic signed [32:0]   zr   [CORDIC_STEPS+1];
  logic                 zero [CORDIC_STEPS+1];
  sqv_pkg::sprite_t     spr  [CORDIC_STEPS+1];

  assign full = (credits == CW'(QDEPTH));
  assign acc  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + CW'(acc) - CW'(release_credit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= acc;
    end
    xr[0]   <= sqv_pkg::GAIN_Q30;
    yr[0]   <= '0;
    zr[0]   <= {3'b000, sprite.turn_angle[13:0], 16'h0000};
    zero[0] <= (sprite.turn_angle[13:0] == 14'd0);
    spr[0]  <= sprite;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [32:0] ATN = $signed({1'b0, sqv_pkg::ATAN_TBL[i]});
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      if (zr[i] >= 0) begin
        xr[i+1] <= xr[i] - (yr[i] >>> i);
        yr[i+1] <= yr[i] + (xr[i] >>> i);
        zr[i+1] <= zr[i] - ATN;
      end else begin
        xr[i+1] <= xr[i] + (yr[i] >>> i);
        yr[i+1] <= yr[i] - (xr[i] >>> i);
        zr[i+1] <= zr[i] + ATN;
      end
      zero[i+1] <= zero[i];
      spr[i+1]  <= spr[i];
    end
  end

  function automatic logic signed [31:0] clampq(input logic signed [32:0] v);
    logic signed [32:0] r;
    if (v > sqv_pkg::ONE_Q30) r = sqv_pkg::ONE_Q30;
    else if (v < -sqv_pkg::ONE_Q30) r = -sqv_pkg::ONE_Q30;
    else r = v;
    return r[31:0];
  endfunction

  logic signed [31:0] c0, s0;
  logic [1:0] quad;

  always_comb begin
    if (zero[CORDIC_STEPS]) begin
      c0 = 32'sd1073741824;
      s0 = '0;
    end else begin
      c0 = clampq(xr[CORDIC_STEPS]);
      s0 = clampq(yr[CORDIC_STEPS]);
    end
    quad    = spr[CORDIC_STEPS].turn_angle[15:14];
    job.spr = spr[CORDIC_STEPS];
    case (quad)
      2'd1: begin job.cos_v = -s0; job.sin_v = c0;  end
      2'd2: begin job.cos_v = -c0; job.sin_v = -s0; end
      2'd3: begin job.cos_v = s0;  job.sin_v = -c0; end
      default: begin job.cos_v = c0; job.sin_v = s0; end
    endcase
  end

  assign job_valid = vld[CORDIC_STEPS];

endmodule
`default_nettype wire

[hw/rtl/sqv_queue.sv]
// sqv_queue: small register queue of jobs between front and back
// depends on sqv_pkg; never overflows because the front holds credits for it
`default_nettype none
module sqv_queue #(
  parameter int QDEPTH = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire sqv_pkg::job_t wr_job,
  output logic               rd_valid,
  output sqv_pkg::job_t      rd_job,
  input  wire logic          rd_en
);

  localparam int AW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  sqv_pkg::job_t mem [QDEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en && rd_valid) begin
        rd_ptr <= (rd_ptr == AW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(wr_en) - CW'(rd_en && rd_valid);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sqv_back.sv]
// sqv_back: per sprite products, then one vertex per cycle into an output register unless held
// depends on sqv_pkg
`default_nettype none
module sqv_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  input  wire sqv_pkg::job_t job,
  output logic               job_take,
  output logic               empty,
  input  wire logic          pop,
  output sqv_pkg::vertex_t   vertex
);

  logic signed [63:0] pa, pb, pc, pd;
  sqv_pkg::sprite_t   ps;
  logic [31:0]        u_right, v_top;
  logic               p_valid;
  logic [1:0]         cnt;
  logic               o_valid;
  logic               emit;

  assign emit     = p_valid && (!o_valid || pop);
  assign job_take = job_valid && (!p_valid || (emit && cnt == sqv_pkg::CORNER_TR));
  assign empty    = !o_valid;

  always_ff @(posedge clk) begin
    if (job_take) begin
      pa <= job.spr.dest_w * job.cos_v;
      pb <= job.spr.dest_h * job.sin_v;
      pc <= job.spr.dest_w * job.sin_v;
      pd <= job.spr.dest_h * job.cos_v;
      ps <= job.spr;
      u_right <= sqv_pkg::sat36(36'(job.spr.tex_x) + 36'(job.spr.tex_w));
      v_top   <= sqv_pkg::sat36(36'(job.spr.tex_y) + 36'(job.spr.tex_h));
    end
  end

  logic sxp, syp;
  logic signed [65:0] rx, ry;
  sqv_pkg::vertex_t vx;

  always_comb begin
    sxp = (cnt == sqv_pkg::CORNER_BR) || (cnt == sqv_pkg::CORNER_TR);
    syp = (cnt == sqv_pkg::CORNER_TL) || (cnt == sqv_pkg::CORNER_TR);
    rx = (sxp ? 66'(pa) : -66'(pa)) + (syp ? -66'(pb) : 66'(pb))
       + $signed({{4{ps.dest_w[31]}}, ps.dest_w, 30'b0}) + 66'sh40000000;
    ry = (sxp ? 66'(pc) : -66'(pc)) + (syp ? 66'(pd) : -66'(pd))
       + $signed({{4{ps.dest_h[31]}}, ps.dest_h, 30'b0}) + 66'sh40000000;
    vx.pos_x = sqv_pkg::sat36(36'(ps.dest_x) + 36'($signed(rx[65:31])));
    vx.pos_y = sqv_pkg::sat36(36'(ps.dest_y) + 36'($signed(ry[65:31])));
    vx.tex_u = sxp ? u_right : ps.tex_x;
    vx.tex_v = syp ? v_top : ps.tex_y;
    vx.out_colour  = ps.colour_rgba;
    vx.out_texture = ps.texture_id;
    vx.out_depth   = ps.depth_value;
    vx.corner      = cnt;
    vx.last_corner = (cnt == sqv_pkg::CORNER_TR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      cnt     <= sqv_pkg::CORNER_TL;
      o_valid <= 1'b0;
    end else begin
      if (job_take) begin
        p_valid <= 1'b1;
      end else if (emit && cnt == sqv_pkg::CORNER_TR) begin
        p_valid <= 1'b0;
      end
      if (emit) begin
        cnt <= cnt + 2'd1;
      end
      if (emit) begin
        o_valid <= 1'b1;
      end else if (pop) begin
        o_valid <= 1'b0;
      end
    end
    if (emit) begin
      vertex <= vx;
    end
  end

  // a sprite never disappears part way through its quad
  a_quad_whole: assert property (@(posedge clk) disable iff (rst)
    emit && cnt != sqv_pkg::CORNER_TR |=> p_valid)
    else $error("sprite dropped mid quad");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> o_valid && vertex.corner == $past(cnt))
    else $error("vertex not registered");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    job_take |=> p_valid && cnt == sqv_pkg::CORNER_TL)
    else $error("new sprite not at first corner");

endmodule
`default_nettype wire

[sim/sprite_quad_vertex_checker.sv]
// sprite_quad_vertex_checker: predicts the four vertices of each accepted sprite and
// compares them with the vertices popped from the core; depends on sqv_pkg
module sprite_quad_vertex_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  sqv_pkg::sprite_t sprite,
  input  logic             empty,
  input  logic             pop,
  input  sqv_pkg::vertex_t vertex,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint GAIN = 64'sd652032874;
  localparam longint ONE  = 64'sd1073741824;
  localparam longint ARCTAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  sqv_pkg::vertex_t vertex_q[$];

  function automatic longint clip(longint v, longint lim_hi, longint lim_lo);
    if (v > lim_hi) return lim_hi;
    if (v < lim_lo) return lim_lo;
    return v;
  endfunction

  function automatic longint sat_word(longint v);
    return clip(v, 64'sd2147483647, -64'sd2147483648);
  endfunction

  // cosine and sine in q1.30, quadrant folded in
  task automatic rotation_of(input logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy, c0, s0;
    z = longint'(ang[13:0]) <<< 16;
    c0 = ONE;
    s0 = 0;
    if (z != 0) begin
      x = GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ARCTAN[i];
        end else begin
          x += dx; y -= dy; z += ARCTAN[i];
        end
      end
      c0 = clip(x, ONE, -ONE);
      s0 = clip(y, ONE, -ONE);
    end
    case (ang[15:14])
      2'd1: begin c = -s0; s = c0; end
      2'd2: begin c = -c0; s = -s0; end
      2'd3: begin c = s0; s = -c0; end
      default: begin c = c0; s = s0; end
    endcase
  endtask

  task automatic predict_quad(input sqv_pkg::sprite_t sp);
    longint c, s, dw, dh, cx, cy, rx, ry, u_right, v_top;
    sqv_pkg::vertex_t v;
    sqv_pkg::corner_t k;
    rotation_of(sp.turn_angle, c, s);
    dw = sp.dest_w;
    dh = sp.dest_h;
    u_right = sat_word(longint'(sp.tex_x) + longint'(sp.tex_w));
    v_top = sat_word(longint'(sp.tex_y) + longint'(sp.tex_h));
    for (int i = 0; i < 4; i++) begin
      k = sqv_pkg::corner_t'(i);
      cx = (k == sqv_pkg::CORNER_TL || k == sqv_pkg::CORNER_BL) ? -dw : dw;
      cy = (k == sqv_pkg::CORNER_BL || k == sqv_pkg::CORNER_BR) ? -dh : dh;
      rx = cx * c - cy * s + dw * ONE + ONE;
      ry = cx * s + cy * c + dh * ONE + ONE;
      v.pos_x = 32'(sat_word(longint'(sp.dest_x) + (rx >>> 31)));
      v.pos_y = 32'(sat_word(longint'(sp.dest_y) + (ry >>> 31)));
      v.tex_u = (k == sqv_pkg::CORNER_TL || k == sqv_pkg::CORNER_BL) ?
                sp.tex_x : 32'(u_right);
      v.tex_v = (k == sqv_pkg::CORNER_BL || k == sqv_pkg::CORNER_BR) ?
                sp.tex_y : 32'(v_top);
      v.out_colour = sp.colour_rgba;
      v.out_texture = sp.texture_id;
      v.out_depth = sp.depth_value;
      v.corner = k;
      v.last_corner = (k == sqv_pkg::CORNER_TR);
      vertex_q.push_back(v);
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    sqv_pkg::vertex_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected vertex %h", $time, vertex);
          errors <= errors + 1;
        end else begin
          e = vertex_q.pop_front();
          if (e.pos_x !== vertex.pos_x || e.pos_y !== vertex.pos_y ||
              e.tex_u !== vertex.tex_u || e.tex_v !== vertex.tex_v ||
              e.out_colour !== vertex.out_colour || e.out_texture !== vertex.out_texture ||
              e.out_depth !== vertex.out_depth || e.corner !== vertex.corner ||
              e.last_corner !== vertex.last_corner) begin
            $display("%0t: vertex mismatch expected %h actual %h", $time, e, vertex);
            errors <= errors + 1;
          end
        end
      end
      if (push && !full) predict_quad(sprite);
    end
    pending = vertex_q.size();
  end
endmodule

[sim/sprite_quad_vertex_gen_core_tb.sv]
// sprite_quad_vertex_gen_core_tb: drives sprites into the core and pops its vertices
// depends on sqv_pkg, sprite_quad_vertex_gen_core and sprite_quad_vertex_checker
module sprite_quad_vertex_gen_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int LIMIT = 400000;

  logic clk = 0, rst = 1, push = 0, pop = 0, hold_pop = 0;
  logic full, empty;
  sqv_pkg::sprite_t sprite = '0;
  sqv_pkg::vertex_t vertex;
  int errors, pending, cycles = 0;
  bit sending_done = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  sprite_quad_vertex_gen_core #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .sprite(sprite),
    .empty(empty), .pop(pop), .vertex(vertex)
  );

  sprite_quad_vertex_checker #(.CORDIC_STEPS(STEPS)) chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .sprite(sprite), .empty(empty),
    .pop(pop), .vertex(vertex), .errors(errors), .pending(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] rand_q(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 400)) - 200) <<< 16;
    endcase
  endfunction

  function automatic sqv_pkg::sprite_t random_sprite();
    sqv_pkg::sprite_t sp;
    int m;
    m = $urandom_range(0, 3);
    sp.dest_x = rand_q(m);
    sp.dest_y = rand_q(m);
    sp.dest_w = rand_q(m);
    sp.dest_h = rand_q(m);
    sp.tex_x = rand_q(m);
    sp.tex_y = rand_q(m);
    sp.tex_w = rand_q(m);
    sp.tex_h = rand_q(m);
    sp.colour_rgba = $urandom;
    sp.texture_id = $urandom;
    sp.depth_value = $urandom;
    sp.turn_angle = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3)) << 14 : 16'($urandom);
    return sp;
  endfunction

  // full is stable at the falling edge, so it tells whether the next rising edge accepts
  task automatic send_sprite(input sqv_pkg::sprite_t sp, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      push <= 0;
      repeat (g) @(negedge clk);
    end
    sprite <= sp;
    push <= 1;
    while (full) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 0;
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (rst || hold_pop) pop <= 0;
    else if (sending_done || $urandom_range(0, 9) != 0) pop <= 1;
    else pop <= 0;
  end

  initial begin
    hold_pop = 0;
    while (1) begin
      @(posedge clk);
      if (!rst) begin
        repeat (200) @(posedge clk);
        hold_pop = 1;
        repeat (300) @(posedge clk);
        hold_pop = 0;
        break;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    sqv_pkg::sprite_t sp;
    longint signed ext[8];
    logic [15:0] ang[8];
    ext = '{32'sh7FFFFFFF, -32'sh80000000, 0, 1, -1, 32'sh00010000, -32'sh00010000, 32'sh40000000};
    ang = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h0001, 16'hFFFF, 16'h2000, 16'h3FFF};
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: field extremes, quarter turns, tiny angles, overflows, negative sizes
    for (int i = 0; i < 24; i++) begin
      sp.dest_x = 32'(ext[i % 8]);
      sp.dest_y = 32'(ext[(i + 3) % 8]);
      sp.dest_w = 32'(ext[(i + 1) % 8]);
      sp.dest_h = 32'(ext[(i + 5) % 8]);
      sp.tex_x = 32'(ext[(i + 2) % 8]);
      sp.tex_y = 32'(ext[(i + 6) % 8]);
      sp.tex_w = 32'(ext[i % 8]);
      sp.tex_h = 32'(ext[(i + 7) % 8]);
      sp.colour_rgba = (i % 2) ? 32'hFFFFFFFF : 32'h0;
      sp.texture_id = (i % 2) ? 32'h0 : 32'hFFFFFFFF;
      sp.depth_value = 32'(ext[(i + 4) % 8]);
      sp.turn_angle = ang[i % 8];
      send_sprite(sp, 0);
    end
    for (int i = 0; i < 360; i++) begin
      // one pause until everything has drained
      if (i == 150) drain();
      send_sprite(random_sprite(), i > 20);
    end
    push <= 0;
    sending_done = 1;
    while (pending != 0 || hold_pop) @(negedge clk);
    repeat (STEPS + 20) @(negedge clk);
    if (errors == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
